// ----- hdl/cnws_pkg.sv -----
// shared types, constants and helpers of the character lcd nibble write sequencer
package cnws_pkg;

  // field widths
  localparam int unsigned OpcodeW  = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibbleW  = 4;
  localparam int unsigned TimeW    = 13;
  localparam int unsigned InitStepW = 3;
  localparam int unsigned CfgIdxW  = 1;

  // enable timing in microseconds
  localparam logic [TimeW-1:0] CmdEnableHighUs  = TimeW'(15);
  localparam logic [TimeW-1:0] DataEnableHighUs = TimeW'(10);
  localparam logic [TimeW-1:0] MidEnableLowUs   = TimeW'(10);

  // settle register reset values
  localparam logic [TimeW-1:0] CmdSettleReset  = TimeW'(5000);
  localparam logic [TimeW-1:0] DataSettleReset = TimeW'(50);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCmdSettle  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDataSettle = CfgIdxW'(1);

  // init sequence
  localparam int unsigned InitLen = 5;
  localparam logic [InitStepW-1:0] InitFirstStep = InitStepW'(1);
  localparam logic [InitStepW-1:0] InitLastChain = InitStepW'(InitLen - 1);
  localparam logic [InitStepW-1:0] InitNone      = InitStepW'(0);

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [OpcodeW-1:0] {
    OP_TICK = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2,
    OP_INIT = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HIGH_E   = 3'd1,
    PH_HIGH_GAP = 3'd2,
    PH_LOW_E    = 3'd3,
    PH_SETTLE   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [ByteW-1:0]   byte_value;
  } in_item_t;

  typedef struct packed {
    logic [NibbleW-1:0] data_nibble;
    logic               rs_level;
    logic               enable_level;
    logic               busy_res;
    logic               rejected;
  } out_item_t;

  // classified request as the back end sees it
  typedef struct packed {
    logic             tick;
    logic             init;
    logic             rs;
    logic [ByteW-1:0] value;
  } req_t;

  typedef struct packed {
    logic               enable;
    logic               rs;
    logic [NibbleW-1:0] nibble;
  } pins_t;

  function automatic logic [ByteW-1:0] init_cmd(input logic [InitStepW-1:0] idx);
    logic [ByteW-1:0] cmd;
    case (idx)
      3'd0:    cmd = 8'h02;
      3'd1:    cmd = 8'h28;
      3'd2:    cmd = 8'h01;
      3'd3:    cmd = 8'h0C;
      3'd4:    cmd = 8'h06;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

  function automatic logic [TimeW-1:0] high_time(input logic rs);
    return rs ? DataEnableHighUs : CmdEnableHighUs;
  endfunction

endpackage

// ----- hdl/char_lcd_nibble_write_sequencer.sv -----
// top level of the character lcd 4-bit nibble write sequencer
//
//  port group   direction  handshake              payload
//  in_*         input      in_valid_i/in_stall_o   in_item_i  (opcode, byte_value)
//  out_*        output     out_valid_o/out_stall_i out_item_o (pins, busy, rejected)
//  cfg_*        input      cfg_we_i                cfg_idx_i, cfg_data_i (settle times)
//
//  one item per cycle sustained while out_stall_i stays low; an accepted item is written
//  into the queue, then popped and loaded into the output register, from which its
//  result is taken; the rate is set by the phase update in the back end
//  reset: settle times 5000 us (command) and 50 us (data), phase idle, pins low
//  a two-item queue takes up to two more items while a result waits on out_stall_i,
//  then in_stall_o rises until the output register drains
module char_lcd_nibble_write_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cnws_pkg::in_item_t            in_item_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cnws_pkg::out_item_t           out_item_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [cnws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cnws_pkg::TimeW-1:0]    cfg_data_i
);
  import cnws_pkg::*;

  // front to queue
  logic push_valid;
  req_t push_req;
  logic q_full;

  // queue to back
  logic pop_valid;
  req_t pop_req;
  logic pop_ready;

  // front end decodes the opcode and picks the byte and rs to send
  cnws_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_req_o   (push_req),
    .q_full_i     (q_full)
  );

  // decoupling queue, stalls the input only when full
  cnws_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_req_i   (push_req),
    .full_o       (q_full),
    .pop_valid_o  (pop_valid),
    .pop_req_o    (pop_req),
    .pop_ready_i  (pop_ready)
  );

  // back end runs the enable phases, counts ticks and chains the init commands
  cnws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pop_valid_i  (pop_valid),
    .pop_req_i    (pop_req),
    .pop_ready_o  (pop_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ----- hdl/cnws_front.sv -----
// front end: accepts items and classifies them into requests
module cnws_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cnws_pkg::in_item_t in_item_i,
  output logic              push_valid_o,
  output cnws_pkg::req_t    push_req_o,
  input  logic              q_full_i
);
  import cnws_pkg::*;

  req_t req;

  always_comb begin
    req       = '0;
    req.value = in_item_i.byte_value;
    case (opcode_e'(in_item_i.opcode))
      OP_TICK: begin
        req.tick  = 1'b1;
        req.value = '0;
      end
      OP_CMD: begin
        req.rs = 1'b0;
      end
      OP_DATA: begin
        req.rs = 1'b1;
      end
      OP_INIT: begin
        req.init  = 1'b1;
        req.value = init_cmd(InitStepW'(0));
      end
      default: begin
        req.tick = 1'b1;
      end
    endcase
  end

  assign push_valid_o = in_valid_i;
  assign push_req_o   = req;
  assign in_stall_o   = q_full_i;

endmodule

// ----- hdl/cnws_fifo.sv -----
// short request queue between front and back
module cnws_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  cnws_pkg::req_t push_req_i,
  output logic           full_o,
  output logic           pop_valid_o,
  output cnws_pkg::req_t pop_req_o,
  input  logic           pop_ready_i
);
  import cnws_pkg::*;

  req_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign full_o      = (cnt_q == QCntW'(QDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_req_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && !full_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// ----- hdl/cnws_back.sv -----
// back end: phase sequencer, settle registers and output register
module cnws_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cnws_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cnws_pkg::TimeW-1:0]          cfg_data_i,
  input  logic                                pop_valid_i,
  input  cnws_pkg::req_t                      pop_req_i,
  output logic                                pop_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cnws_pkg::out_item_t                 out_item_o
);
  import cnws_pkg::*;

  logic [TimeW-1:0]     cmd_settle_q, data_settle_q;
  phase_e               phase_q, phase_d;
  logic [TimeW-1:0]     rem_q, rem_d;
  logic [ByteW-1:0]     byte_q, byte_d;
  logic                 rs_q, rs_d;
  logic [InitStepW-1:0] step_q, step_d;
  pins_t                pins_q, pins_d;
  logic                 rejected_d;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;

  logic                 pop;
  logic                 busy;
  logic                 start;
  logic [ByteW-1:0]     start_val;
  logic                 start_rs;

  assign busy        = (phase_q != PH_IDLE);
  assign pop_ready_o = !out_valid_q || !out_stall_i;
  assign pop         = pop_valid_i && pop_ready_o;

  // settle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_settle_q  <= CmdSettleReset;
      data_settle_q <= DataSettleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCmdSettle:  cmd_settle_q  <= cfg_data_i;
        CfgDataSettle: data_settle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    rem_d      = rem_q;
    byte_d     = byte_q;
    rs_d       = rs_q;
    step_d     = step_q;
    pins_d     = pins_q;
    rejected_d = 1'b0;
    start      = 1'b0;
    start_val  = pop_req_i.value;
    start_rs   = pop_req_i.rs;
    if (pop) begin
      if (pop_req_i.tick) begin
        if (busy) begin
          if (rem_q > TimeW'(1)) begin
            rem_d = rem_q - TimeW'(1);
          end else begin
            case (phase_q)
              PH_HIGH_E: begin
                phase_d       = PH_HIGH_GAP;
                rem_d         = MidEnableLowUs;
                pins_d.enable = 1'b0;
              end
              PH_HIGH_GAP: begin
                phase_d = PH_LOW_E;
                rem_d   = high_time(rs_q);
                pins_d  = '{enable: 1'b1, rs: rs_q, nibble: byte_q[NibbleW-1:0]};
              end
              PH_LOW_E: begin
                phase_d       = PH_SETTLE;
                rem_d         = rs_q ? data_settle_q : cmd_settle_q;
                pins_d.enable = 1'b0;
              end
              PH_SETTLE: begin
                if (step_q >= InitFirstStep && step_q <= InitLastChain) begin
                  // chain the next init command on this same tick
                  step_d    = step_q + InitStepW'(1);
                  start     = 1'b1;
                  start_val = init_cmd(step_q);
                  start_rs  = 1'b0;
                end else begin
                  step_d  = InitNone;
                  phase_d = PH_IDLE;
                  rem_d   = '0;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                rem_d   = '0;
                step_d  = InitNone;
              end
            endcase
          end
        end
      end else if (busy) begin
        rejected_d = 1'b1;
      end else begin
        step_d = pop_req_i.init ? InitFirstStep : InitNone;
        start  = 1'b1;
      end
    end
    if (start) begin
      byte_d  = start_val;
      rs_d    = start_rs;
      phase_d = PH_HIGH_E;
      rem_d   = high_time(start_rs);
      pins_d  = '{enable: 1'b1, rs: start_rs, nibble: start_val[ByteW-1:NibbleW]};
    end
  end

  // result of the item being applied
  always_comb begin
    out_d.data_nibble  = pins_d.nibble;
    out_d.rs_level     = pins_d.rs;
    out_d.enable_level = pins_d.enable;
    out_d.busy_res     = (phase_d != PH_IDLE);
    out_d.rejected     = rejected_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      rem_q       <= '0;
      byte_q      <= '0;
      rs_q        <= 1'b0;
      step_q      <= InitNone;
      pins_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      byte_q  <= byte_d;
      rs_q    <= rs_d;
      step_q  <= step_d;
      pins_q  <= pins_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // busy flag of a result tracks the phase it left behind
  a_busy_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_q.busy_res == (phase_q != PH_IDLE))
    else $error("busy flag disagrees with phase");

  a_reject_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> out_q.busy_res)
    else $error("rejected item while idle");

  a_strobe_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.enable_level |-> out_q.busy_res)
    else $error("enable high while idle");

  a_init_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != InitNone |-> phase_q != PH_IDLE)
    else $error("init step left over while idle");

  a_no_load_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(out_q))
    else $error("held result overwritten");

endmodule

// ----- verif/tb_char_lcd_nibble_write_sequencer.sv -----
// self-checking testbench for the character lcd nibble write sequencer
module tb_char_lcd_nibble_write_sequencer;
  import cnws_pkg::*;

  // run limits: the slowest legal run finishes well before the cycle limit
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned RandomRounds  = 3;
  localparam int unsigned ItemsPerRound = 40;

  logic clk_i;
  logic rst_ni = 1'b0;

  // every block input starts at a known value
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgCmdSettle;
  logic [TimeW-1:0]    cfg_data_i  = '0;

  char_lcd_nibble_write_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // power-up command list of the display
  logic [ByteW-1:0] init_cmd_list [InitLen] = '{8'h02, 8'h28, 8'h01, 8'h0C, 8'h06};

  // shadow copy of the sequencer state and its settle registers
  phase_e              lcd_phase;
  logic [TimeW-1:0]    lcd_left_us;
  logic [ByteW-1:0]    lcd_byte;
  logic                lcd_rs;
  logic [InitStepW-1:0] lcd_init_idx;
  pins_t               shadow_pins;
  logic [TimeW-1:0]    cmd_settle_us;
  logic [TimeW-1:0]    data_settle_us;

  // pin levels still owed by the block, oldest first
  out_item_t pin_expect_q [$];

  bit          idle_on = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned settings_used = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pin_expect_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // pin level predictor
  // ---------------------------------------------------------------------------

  // latch a byte and raise E with its high nibble
  task automatic load_byte(input logic [ByteW-1:0] value, input logic rs);
    lcd_byte           = value;
    lcd_rs             = rs;
    lcd_phase          = PH_HIGH_E;
    lcd_left_us        = rs ? DataEnableHighUs : CmdEnableHighUs;
    shadow_pins.nibble = value[7:4];
    shadow_pins.rs     = rs;
    shadow_pins.enable = 1'b1;
  endtask

  // end of the current timed phase
  task automatic next_phase();
    case (lcd_phase)
      PH_HIGH_E: begin
        // E drops, high nibble stays for the mid gap
        lcd_phase          = PH_HIGH_GAP;
        lcd_left_us        = MidEnableLowUs;
        shadow_pins.enable = 1'b0;
      end
      PH_HIGH_GAP: begin
        lcd_phase          = PH_LOW_E;
        lcd_left_us        = lcd_rs ? DataEnableHighUs : CmdEnableHighUs;
        shadow_pins.nibble = lcd_byte[3:0];
        shadow_pins.enable = 1'b1;
      end
      PH_LOW_E: begin
        // settle time is taken from the register as it stands now
        lcd_phase          = PH_SETTLE;
        lcd_left_us        = lcd_rs ? data_settle_us : cmd_settle_us;
        shadow_pins.enable = 1'b0;
      end
      PH_SETTLE: begin
        if (lcd_init_idx >= InitFirstStep && lcd_init_idx <= InitLastChain) begin
          // init chains straight into its next command on the same tick
          lcd_init_idx++;
          load_byte(init_cmd_list[lcd_init_idx - 1], 1'b0);
        end else begin
          lcd_init_idx = InitNone;
          lcd_phase    = PH_IDLE;
          lcd_left_us  = '0;
        end
      end
      default: begin
        lcd_phase    = PH_IDLE;
        lcd_left_us  = '0;
        lcd_init_idx = InitNone;
      end
    endcase
  endtask

  // apply one accepted item and work out the pins it leaves behind
  task automatic predict_lcd_step(input in_item_t it, output out_item_t res);
    logic was_busy;
    logic dropped;
    was_busy = (lcd_phase != PH_IDLE);
    dropped  = 1'b0;
    if (opcode_e'(it.opcode) == OP_TICK) begin
      // a tick while idle changes nothing
      if (was_busy) begin
        if (lcd_left_us > 1) lcd_left_us--;
        else next_phase();
      end
    end else if (was_busy) begin
      dropped = 1'b1;
    end else begin
      case (opcode_e'(it.opcode))
        OP_CMD: begin
          lcd_init_idx = InitNone;
          load_byte(it.byte_value, 1'b0);
        end
        OP_DATA: begin
          lcd_init_idx = InitNone;
          load_byte(it.byte_value, 1'b1);
        end
        default: begin
          lcd_init_idx = InitFirstStep;
          load_byte(init_cmd_list[0], 1'b0);
        end
      endcase
    end
    res.data_nibble  = shadow_pins.nibble;
    res.rs_level     = shadow_pins.rs;
    res.enable_level = shadow_pins.enable;
    res.busy_res     = (lcd_phase != PH_IDLE);
    res.rejected     = dropped;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // hand one item to the block; valid only drops when a gap is drawn
  task automatic send_item(input opcode_e op, input logic [ByteW-1:0] value);
    int unsigned gap;
    in_item_t    it;
    out_item_t   res;
    gap           = idle_on ? $urandom_range(0, 15) : 0;
    it.opcode     = op;
    it.byte_value = value;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_lcd_step(it, res);
    pin_expect_q.push_back(res);
    items_sent++;
    if (res.rejected) drops_seen++;
  endtask

  // tick byte is don't-care, so keep it random to toggle those bits too
  task automatic send_tick();
    send_item(OP_TICK, ByteW'($urandom_range(0, 255)));
  endtask

  task automatic run_to_idle();
    while (lcd_phase != PH_IDLE) send_tick();
  endtask

  function automatic opcode_e random_request_op();
    case ($urandom_range(0, 2))
      0:       return OP_CMD;
      1:       return OP_DATA;
      default: return OP_INIT;
    endcase
  endfunction

  // stop sending and wait for every owed result, then a few quiet cycles
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pin_expect_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // both settle registers, back to back; only called with the block drained
  task automatic write_settle(input logic [TimeW-1:0] cmd_v, input logic [TimeW-1:0] data_v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgCmdSettle;
    cfg_data_i <= cmd_v;
    @(posedge clk_i);
    cmd_settle_us = cmd_v;
    cfg_idx_i  <= CfgDataSettle;
    cfg_data_i <= data_v;
    @(posedge clk_i);
    data_settle_us = data_v;
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall draw per result and field-by-field compare
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pin_expect_q.size() == 0) begin
        report_mismatch("unexpected result", out_item_o, 0);
      end else begin
        want = pin_expect_q.pop_front();
        if (out_item_o.data_nibble !== want.data_nibble)
          report_mismatch("data_nibble", out_item_o.data_nibble, want.data_nibble);
        if (out_item_o.rs_level !== want.rs_level)
          report_mismatch("rs_level", out_item_o.rs_level, want.rs_level);
        if (out_item_o.enable_level !== want.enable_level)
          report_mismatch("enable_level", out_item_o.enable_level, want.enable_level);
        if (out_item_o.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_item_o.busy_res, want.busy_res);
        if (out_item_o.rejected !== want.rejected)
          report_mismatch("rejected", out_item_o.rejected, want.rejected);
      end
      hold_left = idle_on ? $urandom_range(0, 15) : 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset data settle time: a full data byte at 50 us, with ticks on an idle
  // block before and after
  task automatic test_reset_values();
    idle_on = 1'b0;
    send_tick();
    send_item(OP_DATA, 8'h00);
    run_to_idle();
    send_tick();
    drain_results();
  endtask

  // requests while busy: one on every phase change of a command and a data
  // byte, and one on each settle during init chaining
  task automatic test_busy_rejects();
    phase_e last_phase;
    idle_on = 1'b1;
    write_settle(13'd7, 13'd4);
    for (int k = 0; k < 3; k++) begin
      case (k)
        0:       send_item(OP_CMD, 8'hA5);
        1:       send_item(OP_DATA, 8'h3C);
        default: send_item(OP_INIT, 8'h00);
      endcase
      last_phase = PH_IDLE;
      while (lcd_phase != PH_IDLE) begin
        if (lcd_phase != last_phase &&
            (lcd_init_idx == InitNone || lcd_phase == PH_SETTLE))
          send_item(random_request_op(), ByteW'($urandom_range(0, 255)));
        last_phase = lcd_phase;
        send_tick();
      end
    end
    drain_results();
  endtask

  // zero settle acts as one tick, then the smallest legal value
  task automatic test_settle_extremes();
    idle_on = 1'b1;
    write_settle(13'd0, 13'd0);
    send_item(OP_INIT, 8'hFF);
    run_to_idle();
    send_item(OP_CMD, 8'h5A);
    run_to_idle();
    send_item(OP_DATA, 8'hC3);
    run_to_idle();
    drain_results();
    write_settle(13'd1, 13'd1);
    send_item(OP_CMD, 8'h96);
    run_to_idle();
    send_item(OP_DATA, 8'h69);
    run_to_idle();
    drain_results();
  endtask

  // mostly complete transfers with random bytes and short settle times;
  // stray requests while busy and ticks while idle are mixed in as noise
  task automatic test_random_rounds();
    int unsigned counted;
    int unsigned pick;
    opcode_e     op;
    for (int r = 0; r < RandomRounds; r++) begin
      write_settle(TimeW'($urandom_range(0, 12)), TimeW'($urandom_range(0, 12)));
      // every third round runs with no gaps on either side
      idle_on = (r % 3 != 2);
      counted = 0;
      while (counted < ItemsPerRound) begin
        if (lcd_phase != PH_IDLE) begin
          if ($urandom_range(0, 15) == 0) begin
            send_item(random_request_op(), ByteW'($urandom_range(0, 255)));
          end else begin
            send_tick();
            counted++;
          end
        end else if ($urandom_range(0, 3) == 0) begin
          send_tick();
        end else begin
          pick = $urandom_range(0, 9);
          op   = (pick == 0) ? OP_INIT : (pick < 5) ? OP_CMD : OP_DATA;
          send_item(op, ByteW'($urandom_range(0, 255)));
          counted++;
        end
      end
      run_to_idle();
      drain_results();
    end
  endtask

  initial begin
    // shadow state matches the block coming out of reset
    lcd_phase      = PH_IDLE;
    lcd_left_us    = '0;
    lcd_byte       = '0;
    lcd_rs         = 1'b0;
    lcd_init_idx   = InitNone;
    shadow_pins    = '0;
    cmd_settle_us  = CmdSettleReset;
    data_settle_us = DataSettleReset;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_busy_rejects();
    test_settle_extremes();
    test_random_rounds();
    drain_results();

    $display("run covered %0d items and %0d results, %0d requests dropped while busy,",
             items_sent, results_seen, drops_seen);
    $display("over %0d settle register settings including zero and one",
             settings_used);
    if (pin_expect_q.size() != 0)
      report_mismatch("results never delivered", 0, pin_expect_q.size());
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/cnws_pkg.sv
hdl/cnws_front.sv
hdl/cnws_fifo.sv
hdl/cnws_back.sv
hdl/char_lcd_nibble_write_sequencer.sv
verif/tb_char_lcd_nibble_write_sequencer.sv
